// ===== rtl/core/integer_to_ascii_formatter_assert.svh =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter assertion macros
// Concurrent assertion wrappers shared by the formatter RTL. They expand to
// nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is high.
`define ITOA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ITOA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ITOA_ASSERT(name, clk, rst, prop, msg)
`define ITOA_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared types, command codes, character constants and the digit encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itoa_pkg;

   // Command codes carried on the input tuser.
   localparam logic [1:0] CMD_DEC       = 2'd0;
   localparam logic [1:0] CMD_HEX_LOWER = 2'd1;
   localparam logic [1:0] CMD_HEX_UPPER = 2'd2;

   // Character constants.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] UPPER_BASE = 8'h40;
   localparam logic [7:0] LOWER_BASE = 8'h60;

   // Largest field width honored; larger requests saturate.
   localparam logic [3:0] WIDTH_MAX = 4'd9;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // Formatting controls handed to the character emitter.
   typedef struct packed {
      logic       neg;
      logic       hex;
      logic       upper;
      logic       zpad;
      logic [3:0] width;
   } emit_cmd_type;

   // ASCII code of one decimal or hex digit.
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] base;
      base = upper ? UPPER_BASE : LOWER_BASE;
      if (d < 4'd10) begin
         digit_char = CHAR_ZERO + {4'b0000, d};
      end else begin
         digit_char = {4'b0000, d} - 8'd9 + base;
      end
   endfunction

endpackage

// ===== rtl/core/itoa_dabble.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter digit converter
// Bit-serial double-dabble converter: the magnitude shifts into a BCD
// register one bit per cycle. Hex values load their nibbles directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_dabble #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  hex,
   input  logic [VALUE_BITS-1:0] value,
   output logic                  done,
   output logic [4*DIGITS-1:0]   digits
);

   localparam int CW = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [4*DIGITS-1:0]   bcd_ff, bcd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [VALUE_BITS-1:0] mag;
   logic [4*DIGITS-1:0]   adj;

   // Magnitude of a signed decimal value; hex keeps the raw bit pattern.
   assign mag = (!hex && value[VALUE_BITS-1]) ? (~value + 1'b1) : value;

   // Add three to every digit of five or more before the shift.
   always_comb begin
      logic [3:0] dgt;
      adj = '0;
      for (int i = 0; i < DIGITS; i++) begin
         dgt = bcd_ff[4*i +: 4];
         adj[4*i +: 4] = (dgt >= 4'd5) ? (dgt + 4'd3) : dgt;
      end
   end

   // Load, shift and count.
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = mag;
         cnt_in = '0;
         if (hex) begin
            bcd_in  = (4*DIGITS)'(value);
            done_in = 1'b1;
         end else begin
            bcd_in = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         bcd_in = {adj[4*DIGITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = bin_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(VALUE_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

// ===== rtl/core/itoa_emitter.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter character emitter
// Scans the digit register from the top position down, one position per cycle
// unless stalled, placing sign, padding and digits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itoa_emitter
   import itoa_pkg::*;
#(
   parameter int DIGITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  emit_cmd_type        cmd,
   input  logic [4*DIGITS-1:0] digits,
   output logic                done,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // character[7:0]
   output logic                rsp_tlast
);

   localparam int PW = $clog2(DIGITS);

   emit_cmd_type        cmd_ff, cmd_in;
   logic [4*DIGITS-1:0] dig_ff, dig_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic                run_ff, run_in;
   logic                seen_ff, seen_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;

   logic                step;
   logic [3:0]          fill;
   logic [3:0]          top_dig, nxt_dig;
   logic                active_cur, active_nxt;
   logic                sign_here, space_here, emit;
   logic [7:0]          chr;

   // Decide what the current position contributes.
   always_comb begin
      step    = run_ff && (!out_valid_ff || rsp_tready);
      fill    = cmd_ff.zpad ? (cmd_ff.width + {3'b000, cmd_ff.neg}) : 4'd0;
      top_dig = dig_ff[4*DIGITS-1 -: 4];
      nxt_dig = dig_ff[4*DIGITS-5 -: 4];
      // A position is part of the digit field once a significant digit or
      // the zero-fill length has been reached.
      active_cur = seen_ff || (top_dig != 4'd0) || (pos_ff == '0) ||
                   (pos_ff < PW'(fill));
      active_nxt = (nxt_dig != 4'd0) || (pos_ff == PW'(1)) || (pos_ff <= PW'(fill));
      sign_here  = cmd_ff.neg && !active_cur && active_nxt;
      space_here = !cmd_ff.zpad && !cmd_ff.hex && !active_cur && !sign_here &&
                   (pos_ff < PW'(cmd_ff.width));
      emit       = active_cur || sign_here || space_here;
      if (active_cur) begin
         chr = digit_char(top_dig, cmd_ff.upper);
      end else if (sign_here) begin
         chr = CHAR_MINUS;
      end else begin
         chr = CHAR_SPACE;
      end
   end

   // Scan sequencing and output register.
   always_comb begin
      cmd_in       = cmd_ff;
      dig_in       = dig_ff;
      pos_in       = pos_ff;
      run_in       = run_ff;
      seen_in      = seen_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      char_in      = char_ff;
      last_in      = last_ff;
      if (start) begin
         cmd_in  = cmd;
         dig_in  = digits;
         pos_in  = PW'(DIGITS - 1);
         run_in  = 1'b1;
         seen_in = 1'b0;
      end else if (step) begin
         dig_in  = dig_ff << 4;
         pos_in  = pos_ff - 1'b1;
         seen_in = active_cur;
         if (pos_ff == '0) begin
            run_in = 1'b0;
         end
         if (emit) begin
            out_valid_in = 1'b1;
            char_in      = chr;
            last_in      = (pos_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         run_ff       <= run_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      dig_ff  <= dig_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign done       = step && (pos_ff == '0);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Formats one integer per item as signed decimal or hex ASCII text, most
// significant character first, with optional zero or space padding.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Payload
// req      in         tuser: command[1:0]
//                     tdata: value[VALUE_BITS-1:0], zero_pad, field_width[3:0]
// rsp      out        tdata: character[7:0]; tlast: last
//
// Decimal items run through the double-dabble converter, which shifts one
// magnitude bit per cycle; the emitter then scans one digit position per cycle
// while the output register can take a character, over eleven at 32 bits.
// Hex items skip the shift.
// One item is in work at a time; the next is taken while the final character
// still waits in the output register.
// Reset is synchronous and clears all control state.
// A low rsp_tready holds the scan until the output register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // value[VALUE_BITS-1:0], zero_pad, field_width[3:0], zero fill
   input  logic [((VALUE_BITS + 5 + 7) / 8) * 8-1:0] req_tdata,
   input  logic [1:0]                               req_tuser,   // command[1:0]
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [7:0]                               rsp_tdata,   // character[7:0]
   output logic                                     rsp_tlast
);

   localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
   // Room for the longest digit field (a full zero fill is one more than the
   // widest field width) plus one position for the sign.
   localparam int DIGITS     = ((DEC_DIGITS > 10) ? DEC_DIGITS : 10) + 1;

   state_type             state_ff, state_in;
   emit_cmd_type          cmd_ff, cmd_in;
   logic                  accept;
   logic                  conv_done, emit_done, emit_start;
   logic [VALUE_BITS-1:0] value;
   logic [3:0]            field_width;
   logic [4*DIGITS-1:0]   digits;

   assign value       = req_tdata[VALUE_BITS-1:0];
   assign field_width = req_tdata[VALUE_BITS+4 -: 4];
   assign accept      = req_tvalid && req_tready;

   // Decode the command and clamp the field width.
   always_comb begin
      cmd_in.zpad  = req_tdata[VALUE_BITS];
      cmd_in.width = (field_width > WIDTH_MAX) ? WIDTH_MAX : field_width;
      unique case (req_tuser)
         CMD_DEC: begin
            cmd_in.hex   = 1'b0;
            cmd_in.upper = 1'b0;
         end
         CMD_HEX_LOWER: begin
            cmd_in.hex   = 1'b1;
            cmd_in.upper = 1'b0;
         end
         CMD_HEX_UPPER: begin
            cmd_in.hex   = 1'b1;
            cmd_in.upper = 1'b1;
         end
         default: begin
            cmd_in.hex   = 1'b1;
            cmd_in.upper = 1'b1;
         end
      endcase
      cmd_in.neg = !cmd_in.hex && value[VALUE_BITS-1];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept)    state_in = ST_CONVERT;
         ST_CONVERT: if (conv_done) state_in = ST_EMIT;
         ST_EMIT:    if (emit_done) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      emit_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_CONVERT: emit_start = conv_done;
         ST_EMIT:    emit_start = 1'b0;
         default:    req_tready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Formatting controls are held for the whole item.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   itoa_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .hex    (cmd_in.hex),
      .value  (value),
      .done   (conv_done),
      .digits (digits)
   );

   itoa_emitter #(
      .DIGITS (DIGITS)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .start      (emit_start),
      .cmd        (cmd_ff),
      .digits     (digits),
      .done       (emit_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Checks on sequencing between converter, emitter and output register.
   `ITOA_ASSERT(a_conv_done_in_convert, clock, reset, conv_done |-> (state_ff == ST_CONVERT), "converter finished outside the convert state")
   `ITOA_ASSERT(a_emit_done_in_emit, clock, reset, emit_done |-> (state_ff == ST_EMIT), "emitter finished outside the emit state")
   `ITOA_ASSERT(a_done_leaves_last, clock, reset, emit_done |=> (rsp_tvalid && rsp_tlast), "scan ended without a final character")
   `ITOA_ASSERT(a_idle_only_last, clock, reset, ((state_ff == ST_IDLE) && rsp_tvalid) |-> rsp_tlast, "non-final character pending while idle")

endmodule
